@@ hdl/pcbg_pkg.sv @@
// Types, constants and the round function of the counter block generator.
package pcbg_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_SEED   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOMAIN = 2'd1;

   localparam logic [31:0] MUL_A  = 32'hd2511f53;
   localparam logic [31:0] MUL_B  = 32'hcd9e8d57;
   localparam logic [31:0] BUMP_A = 32'h9e3779b9;
   localparam logic [31:0] BUMP_B = 32'hbb67ae85;

   localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MULT_A   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MULT_B   = 64'h94d049bb133111eb;
   localparam logic [63:0] DOMAIN_MULT  = 64'hd2b74407b1ce6e93;

   typedef struct packed {
      logic [63:0] source_id;
      logic [63:0] chunk_index;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } rsp_payload_type;

   typedef logic [3:0][31:0] block_type;

   // One Philox4x32 round with the given round key.
   function automatic block_type philox_round(block_type x, logic [31:0] k0,
                                              logic [31:0] k1);
      logic [63:0] pa;
      logic [63:0] pb;
      block_type   y;
      pa   = 64'(MUL_A) * 64'(x[0]);
      pb   = 64'(MUL_B) * 64'(x[2]);
      y[0] = pb[63:32] ^ x[1] ^ k0;
      y[1] = pb[31:0];
      y[2] = pa[63:32] ^ x[3] ^ k1;
      y[3] = pa[31:0];
      return y;
   endfunction

endpackage

@@ hdl/philox_counter_block_generator.sv @@
// Top level of the counter block generator: key derivation and the round pipeline.
//
//  Channel   Direction  Handshake            Content
//  req_      in         req_valid/req_ready  source_id, chunk_index
//  rsp_      out        rsp_valid/rsp_ready  word0 .. word3
//  csr_      in         csr_we               seed (index 0), domain (index 1)
//
// One item is accepted per cycle while req_ready is high; each item passes through
// one pipeline stage holding the counter and one stage for each round.
// After reset and after every register write the key is derived again by a shared
// 32 by 32 bit multiplier, and req_ready is low until it is done.
// Each stage holds its item until the next stage is free, so a stalled result
// only blocks the unbroken run of full stages directly behind it.
module philox_counter_block_generator #(
   parameter int ROUNDS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  pcbg_pkg::req_payload_type             req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output pcbg_pkg::rsp_payload_type             rsp_payload,
   input  logic                                  csr_we,
   input  logic [pcbg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pcbg_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] ST_IDLE = 4'd0;
   localparam logic [STATE_W-1:0] ST_D0   = 4'd1;
   localparam logic [STATE_W-1:0] ST_D1   = 4'd2;
   localparam logic [STATE_W-1:0] ST_D2   = 4'd3;
   localparam logic [STATE_W-1:0] ST_SEED = 4'd4;
   localparam logic [STATE_W-1:0] ST_A0   = 4'd5;
   localparam logic [STATE_W-1:0] ST_A1   = 4'd6;
   localparam logic [STATE_W-1:0] ST_A2   = 4'd7;
   localparam logic [STATE_W-1:0] ST_A3   = 4'd8;
   localparam logic [STATE_W-1:0] ST_B0   = 4'd9;
   localparam logic [STATE_W-1:0] ST_B1   = 4'd10;
   localparam logic [STATE_W-1:0] ST_B2   = 4'd11;
   localparam logic [STATE_W-1:0] ST_B3   = 4'd12;

   logic [63:0]        seed_ff;
   logic [31:0]        domain_ff;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [63:0]        acc_ff, acc_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        key_ff, key_in;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mix_sum, seed_sum;

   pcbg_pkg::block_type blk_ff [0:ROUNDS];
   pcbg_pkg::block_type blk_in [0:ROUNDS];
   logic [ROUNDS:0]     vld_ff;
   logic [ROUNDS:0]     adv;
   logic                req_fire;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         domain_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pcbg_pkg::CSR_SEED:   seed_ff   <= csr_wdata;
            pcbg_pkg::CSR_DOMAIN: domain_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Key derivation: the 64-bit products are built from 32 by 32 bit partial products.
   assign mix_sum  = acc_ff + {prod_ff[31:0], 32'b0};
   assign seed_sum = (seed_ff ^ acc_ff) + pcbg_pkg::GOLDEN_GAMMA;
   assign prod_in  = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      v_in     = v_ff;
      key_in   = key_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         ST_IDLE: ;
         ST_D0: begin
            mul_a    = domain_ff;
            mul_b    = pcbg_pkg::DOMAIN_MULT[31:0];
            state_in = ST_D1;
         end
         ST_D1: begin
            mul_a    = domain_ff;
            mul_b    = pcbg_pkg::DOMAIN_MULT[63:32];
            acc_in   = prod_ff;
            state_in = ST_D2;
         end
         ST_D2: begin
            acc_in   = mix_sum;
            state_in = ST_SEED;
         end
         ST_SEED: begin
            v_in     = seed_sum ^ (seed_sum >> 30);
            state_in = ST_A0;
         end
         ST_A0: begin
            mul_a    = v_ff[31:0];
            mul_b    = pcbg_pkg::MIX_MULT_A[31:0];
            state_in = ST_A1;
         end
         ST_A1: begin
            mul_a    = v_ff[31:0];
            mul_b    = pcbg_pkg::MIX_MULT_A[63:32];
            acc_in   = prod_ff;
            state_in = ST_A2;
         end
         ST_A2: begin
            mul_a    = v_ff[63:32];
            mul_b    = pcbg_pkg::MIX_MULT_A[31:0];
            acc_in   = mix_sum;
            state_in = ST_A3;
         end
         ST_A3: begin
            v_in     = mix_sum ^ (mix_sum >> 27);
            state_in = ST_B0;
         end
         ST_B0: begin
            mul_a    = v_ff[31:0];
            mul_b    = pcbg_pkg::MIX_MULT_B[31:0];
            state_in = ST_B1;
         end
         ST_B1: begin
            mul_a    = v_ff[31:0];
            mul_b    = pcbg_pkg::MIX_MULT_B[63:32];
            acc_in   = prod_ff;
            state_in = ST_B2;
         end
         ST_B2: begin
            mul_a    = v_ff[63:32];
            mul_b    = pcbg_pkg::MIX_MULT_B[31:0];
            acc_in   = mix_sum;
            state_in = ST_B3;
         end
         ST_B3: begin
            key_in   = mix_sum ^ (mix_sum >> 31);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) begin
         state_in = ST_D0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_D0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      v_ff    <= v_in;
      prod_ff <= prod_in;
      key_ff  <= key_in;
   end

   // Round pipeline.
   assign adv[ROUNDS] = !vld_ff[ROUNDS] || rsp_ready;
   for (genvar j = 0; j < ROUNDS; j++) begin : g_adv
      assign adv[j] = !vld_ff[j] || adv[j+1];
   end

   assign req_ready = adv[0] && (state_ff == ST_IDLE) && !csr_we;
   assign req_fire  = req_valid && req_ready;

   assign blk_in[0] = {req_payload.chunk_index[63:32], req_payload.chunk_index[31:0],
                       req_payload.source_id[63:32], req_payload.source_id[31:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         vld_ff[0] <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         blk_ff[0] <= blk_in[0];
      end
   end

   for (genvar j = 1; j <= ROUNDS; j++) begin : g_round
      localparam logic [63:0] OFS_A = 64'(j - 1) * 64'(pcbg_pkg::BUMP_A);
      localparam logic [63:0] OFS_B = 64'(j - 1) * 64'(pcbg_pkg::BUMP_B);

      assign blk_in[j] = pcbg_pkg::philox_round(blk_ff[j-1],
                                                key_ff[31:0] + OFS_A[31:0],
                                                key_ff[63:32] + OFS_B[31:0]);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j] && vld_ff[j-1]) begin
            blk_ff[j] <= blk_in[j];
         end
      end
   end

   assign rsp_valid         = vld_ff[ROUNDS];
   assign rsp_payload.word0 = blk_ff[ROUNDS][0];
   assign rsp_payload.word1 = blk_ff[ROUNDS][1];
   assign rsp_payload.word2 = blk_ff[ROUNDS][2];
   assign rsp_payload.word3 = blk_ff[ROUNDS][3];

endmodule

@@ hdl/pcbg_checker.sv @@
// Port-level checks of the counter block generator and their binding to the top level.
module pcbg_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pcbg_pkg::rsp_payload_type rsp_payload,
   input logic                      csr_we
);

   // After reset no result is shown and no item is taken while the key is derived.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("result or ready seen straight after reset");

   // A register write blocks items in its own cycle and in the next one.
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> !req_ready ##1 !req_ready)
      else $error("item could be taken around a register write");

   // A result that is not taken stays, unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or vanished");

endmodule

bind philox_counter_block_generator pcbg_checker u_pcbg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_we      (csr_we)
);
